/* hdl/vps_pkg.sv */
// vps_pkg: shared types, codes and constants for the vibration pattern sequencer
// used by vps_div100 and vibration_pattern_sequencer; no dependencies
package vps_pkg;

  localparam int STEP_SLOTS = 16;
  localparam int SLOT_AW    = (STEP_SLOTS > 1) ? $clog2(STEP_SLOTS) : 1;
  localparam int CNT_W      = $clog2(STEP_SLOTS + 1);

  localparam int DUR_W      = 16;
  localparam int NUM_W      = 8;
  localparam int PROD_W     = DUR_W + NUM_W;
  localparam int POS_W      = 5;

  // floor(p / 100) as (p * DIV_K) >> DIV_S, exact for every PROD_W-bit product
  localparam int DIV_S      = 31;
  localparam int DIV_K_W    = 25;
  localparam logic [DIV_K_W-1:0] DIV_K = 25'd21474837;
  localparam int QUO_W      = PROD_W + DIV_K_W - DIV_S;

  localparam logic [NUM_W-1:0] NUM_UNITY      = 8'd100;
  localparam logic [NUM_W-1:0] NUM_WEAK_ON    = 8'd80;
  localparam logic [NUM_W-1:0] NUM_WEAK_GAP   = 8'd150;
  localparam logic [NUM_W-1:0] NUM_STRONG_ON  = 8'd145;
  localparam logic [NUM_W-1:0] NUM_STRONG_GAP = 8'd50;

  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PLAY   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HOLD   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STOP   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ENABLE = 3'd5;

  localparam int STR_W = 2;
  localparam logic [STR_W-1:0] STR_WEAK   = 2'd0;
  localparam logic [STR_W-1:0] STR_NORMAL = 2'd1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 2'd1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DUR_W-1:0]  duration;
    logic              scale_it;
    logic              force_req;
    logic              enable_flag;
  } in_item_t;

  typedef struct packed {
    logic             pin_level;
    logic             busy_res;
    logic [POS_W-1:0] step_position;
  } out_item_t;

endpackage

/* hdl/vibration_pattern_sequencer.sv */
// vibration_pattern_sequencer: top level of the on/off pattern player
// depends on vps_pkg and vps_div100
//
// usage
//   in_valid/in_stall/in_data carry one command transaction: tick, load step,
//   play, hold, stop or set enable. every transaction yields exactly one result
//   transaction on out_valid/out_stall/out_data with the pin level, busy flag
//   and step position after that command.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write strength (index 0) and
//   active_low (index 1); cfg_ready is always high. write only while idle.
// throughput and pipeline
//   one transaction per cycle sustained while out_stall stays low. the step store
//   read and the duration multiply are registered when a transaction is accepted;
//   the state update and the divide by 100 are combinational from those registers
//   and the result register loads when the work stage fires.
//   the step store is a 16-entry synchronous ram with one write and one read
//   port; a read colliding with a same-cycle load is forwarded.
// reset
//   rst_n is synchronous; strength returns to normal, polarity to active high,
//   the motor is off and nothing is loaded. store contents are kept.
// back-pressure
//   the result register holds while it is valid and out_stall is high; in_stall rises only
//   when both the result register and the work stage are full.
module vibration_pattern_sequencer
  import vps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // config
  logic [STR_W-1:0] strength_r;
  logic             active_low_r;

  // pipeline control
  logic      item_v_r, out_v_r;
  in_item_t  item_r;
  out_item_t out_data_r;
  logic      adv, fire, in_acc;

  // state
  logic [CNT_W-1:0] load_count_r, load_count_nxt;
  logic [CNT_W-1:0] pattern_length_r, pattern_length_nxt;
  logic [CNT_W-1:0] step_index_r, step_index_nxt;
  logic [DUR_W-1:0] remaining_ms_r, remaining_ms_nxt;
  logic             pattern_running_r, pattern_running_nxt;
  logic             hold_running_r, hold_running_nxt;
  logic             enabled_r, enabled_nxt;
  logic             forced_r, forced_nxt;
  logic             motor_on_r, motor_on_nxt;
  logic             end_out;

  // step store
  logic [DUR_W-1:0]   mem [STEP_SLOTS];
  logic [DUR_W-1:0]   mem_q_r;
  logic [DUR_W-1:0]   fwd_data_r;
  logic               fwd_v_r;
  logic [DUR_W-1:0]   rd_data;
  logic [SLOT_AW-1:0] raddr, waddr;
  logic [CNT_W-1:0]   next_slot;
  logic               we;

  // scaling
  logic [NUM_W-1:0]  num;
  logic              is_on;
  logic [PROD_W-1:0] prod_r;
  logic [DUR_W-1:0]  quo;
  logic [DUR_W-1:0]  scaled;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strength_r   <= STR_NORMAL;
      active_low_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STRENGTH:   strength_r   <= cfg_data[STR_W-1:0];
        CFG_ACTIVE_LOW: active_low_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign adv      = !out_v_r || !out_stall;
  assign fire     = item_v_r && adv;
  assign in_stall = item_v_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        item_v_r <= 1'b1;
      end else if (fire) begin
        item_v_r <= 1'b0;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // first stage: store read and duration multiply
  assign is_on = (in_data.mode == MODE_HOLD) || !load_count_nxt[0];

  always_comb begin
    priority if (strength_r == STR_NORMAL) begin
      num = NUM_UNITY;
    end else if (strength_r == STR_WEAK) begin
      num = is_on ? NUM_WEAK_ON : NUM_WEAK_GAP;
    end else begin
      num = is_on ? NUM_STRONG_ON : NUM_STRONG_GAP;
    end
  end

  assign next_slot = step_index_nxt + 1'b1;
  assign raddr     = (in_data.mode == MODE_PLAY) ? '0 : next_slot[SLOT_AW-1:0];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r     <= in_data;
      prod_r     <= PROD_W'(in_data.duration) * PROD_W'(num);
      mem_q_r    <= mem[raddr];
      fwd_data_r <= scaled;
    end
    if (we) begin
      mem[waddr] <= scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else if (in_acc) begin
      fwd_v_r <= we && (waddr == raddr);
    end
  end

  // second stage: state update
  vps_div100 u_div (
    .prod (prod_r),
    .quo  (quo)
  );

  assign scaled  = item_r.scale_it ? quo : item_r.duration;
  assign rd_data = fwd_v_r ? fwd_data_r : mem_q_r;
  assign waddr   = load_count_r[SLOT_AW-1:0];
  assign we      = fire && (item_r.mode == MODE_LOAD) &&
                   (load_count_r < CNT_W'(STEP_SLOTS));

  always_comb begin
    load_count_nxt      = load_count_r;
    pattern_length_nxt  = pattern_length_r;
    step_index_nxt      = step_index_r;
    remaining_ms_nxt    = remaining_ms_r;
    pattern_running_nxt = pattern_running_r;
    hold_running_nxt    = hold_running_r;
    enabled_nxt         = enabled_r;
    forced_nxt          = forced_r;
    motor_on_nxt        = motor_on_r;
    end_out             = 1'b0;
    if (fire) begin
      unique case (item_r.mode)
        MODE_TICK: begin
          if (hold_running_r) begin
            if (remaining_ms_r <= DUR_W'(1)) begin
              end_out = 1'b1;
            end else begin
              remaining_ms_nxt = remaining_ms_r - 1'b1;
            end
          end else if (pattern_running_r) begin
            if (remaining_ms_r <= DUR_W'(1)) begin
              step_index_nxt = step_index_r + 1'b1;
              if (step_index_nxt >= pattern_length_r) begin
                end_out = 1'b1;
              end else begin
                motor_on_nxt     = !step_index_nxt[0];
                remaining_ms_nxt = rd_data;
              end
            end else begin
              remaining_ms_nxt = remaining_ms_r - 1'b1;
            end
          end
        end
        MODE_LOAD: begin
          if (load_count_r < CNT_W'(STEP_SLOTS)) begin
            load_count_nxt = load_count_r + 1'b1;
          end
        end
        MODE_PLAY: begin
          if (enabled_r && (load_count_r != '0)) begin
            hold_running_nxt    = 1'b0;
            forced_nxt          = item_r.force_req;
            pattern_length_nxt  = load_count_r;
            load_count_nxt      = '0;
            step_index_nxt      = '0;
            pattern_running_nxt = 1'b1;
            motor_on_nxt        = 1'b1;
            remaining_ms_nxt    = rd_data;
          end
        end
        MODE_HOLD: begin
          pattern_running_nxt = 1'b0;
          pattern_length_nxt  = '0;
          step_index_nxt      = '0;
          forced_nxt          = item_r.force_req;
          motor_on_nxt        = 1'b1;
          hold_running_nxt    = 1'b1;
          remaining_ms_nxt    = scaled;
        end
        MODE_STOP: begin
          if (!forced_r || item_r.force_req) begin
            end_out = 1'b1;
          end
        end
        MODE_ENABLE: begin
          enabled_nxt = item_r.enable_flag;
          if (!item_r.enable_flag && !forced_r) begin
            end_out = 1'b1;
          end
        end
        default: ;
      endcase
      if (end_out) begin
        motor_on_nxt        = 1'b0;
        pattern_running_nxt = 1'b0;
        hold_running_nxt    = 1'b0;
        step_index_nxt      = '0;
        pattern_length_nxt  = '0;
        remaining_ms_nxt    = '0;
        forced_nxt          = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r      <= '0;
      pattern_length_r  <= '0;
      step_index_r      <= '0;
      remaining_ms_r    <= '0;
      pattern_running_r <= 1'b0;
      hold_running_r    <= 1'b0;
      enabled_r         <= 1'b1;
      forced_r          <= 1'b0;
      motor_on_r        <= 1'b0;
    end else begin
      load_count_r      <= load_count_nxt;
      pattern_length_r  <= pattern_length_nxt;
      step_index_r      <= step_index_nxt;
      remaining_ms_r    <= remaining_ms_nxt;
      pattern_running_r <= pattern_running_nxt;
      hold_running_r    <= hold_running_nxt;
      enabled_r         <= enabled_nxt;
      forced_r          <= forced_nxt;
      motor_on_r        <= motor_on_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r.pin_level     <= motor_on_nxt ^ active_low_r;
      out_data_r.busy_res      <= pattern_running_nxt || hold_running_nxt;
      out_data_r.step_position <= pattern_running_nxt ? POS_W'(step_index_nxt) : '0;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // checks
  a_one_activity: assert property (@(posedge clk) disable iff (!rst_n)
    !(pattern_running_r && hold_running_r))
    else $error("pattern and hold running together");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pattern_running_r |-> (step_index_r < pattern_length_r))
    else $error("step index past pattern length");

  a_forced_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
    forced_r |-> (pattern_running_r || hold_running_r))
    else $error("forced flag set while idle");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (item_v_r && out_v_r && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule

/* hdl/vps_div100.sv */
// vps_div100: divides a scaled duration product by 100 and saturates to 16 bits
// reciprocal multiply with constants from vps_pkg
module vps_div100
  import vps_pkg::*;
(
  input  logic [PROD_W-1:0] prod,
  output logic [DUR_W-1:0]  quo
);

  logic [PROD_W+DIV_K_W-1:0] full;
  logic [QUO_W-1:0]          q;

  assign full = (PROD_W+DIV_K_W)'(prod) * (PROD_W+DIV_K_W)'(DIV_K);
  assign q    = full[PROD_W+DIV_K_W-1:DIV_S];
  assign quo  = (q > QUO_W'({DUR_W{1'b1}})) ? {DUR_W{1'b1}} : q[DUR_W-1:0];

endmodule

/* test/pattern_player_checker.sv */
// pattern_player_checker: watches the command, result and register channels of
// vibration_pattern_sequencer, predicts each result and compares it field by field
// depends on vps_pkg
module pattern_player_checker
  import vps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    levels_due,
  output int                    mismatches
);

  logic [DUR_W-1:0] slots [STEP_SLOTS];
  logic [CNT_W-1:0] loaded;
  logic [CNT_W-1:0] plen;
  logic [POS_W-1:0] pos;
  logic [DUR_W-1:0] left_ms;
  logic             playing;
  logic             holding;
  logic             allowed;
  logic             pinned;
  logic             motor;
  logic [STR_W-1:0] strength;
  logic             active_low;
  out_item_t        pending_levels [$];

  function automatic logic [DUR_W-1:0] scale_dur(logic [DUR_W-1:0] ms, logic is_on);
    int unsigned factor;
    int unsigned prod;
    if (strength == STR_NORMAL) return ms;
    if (strength == STR_WEAK) factor = 32'(is_on ? NUM_WEAK_ON : NUM_WEAK_GAP);
    else factor = 32'(is_on ? NUM_STRONG_ON : NUM_STRONG_GAP);
    prod = (32'(ms) * factor) / 32'(NUM_UNITY);
    return (prod > 32'hFFFF) ? 16'hFFFF : DUR_W'(prod);
  endfunction

  function automatic void silence_motor();
    motor   = 1'b0;
    playing = 1'b0;
    holding = 1'b0;
    pos     = '0;
    plen    = '0;
    left_ms = '0;
    pinned  = 1'b0;
  endfunction

  function automatic void enter_step();
    motor   = !pos[0];
    left_ms = slots[pos[SLOT_AW-1:0]];
  endfunction

  function automatic out_item_t advance_player(in_item_t cmd);
    out_item_t res;
    case (cmd.mode)
      MODE_TICK: begin
        if (holding) begin
          if (left_ms <= 1) silence_motor();
          else left_ms = left_ms - 1'b1;
        end else if (playing) begin
          if (left_ms <= 1) begin
            pos = pos + 1'b1;
            if (pos >= plen) silence_motor();
            else enter_step();
          end else begin
            left_ms = left_ms - 1'b1;
          end
        end
      end
      MODE_LOAD: begin
        if (loaded < CNT_W'(STEP_SLOTS)) begin
          slots[loaded[SLOT_AW-1:0]] = cmd.scale_it ? scale_dur(cmd.duration, !loaded[0])
                                                    : cmd.duration;
          loaded = loaded + 1'b1;
        end
      end
      MODE_PLAY: begin
        if (allowed && loaded != 0) begin
          holding = 1'b0;
          pinned  = cmd.force_req;
          plen    = loaded;
          loaded  = '0;
          pos     = '0;
          playing = 1'b1;
          enter_step();
        end
      end
      MODE_HOLD: begin
        playing = 1'b0;
        plen    = '0;
        pos     = '0;
        pinned  = cmd.force_req;
        motor   = 1'b1;
        holding = 1'b1;
        left_ms = cmd.scale_it ? scale_dur(cmd.duration, 1'b1) : cmd.duration;
      end
      MODE_STOP: begin
        if (!pinned || cmd.force_req) silence_motor();
      end
      MODE_ENABLE: begin
        allowed = cmd.enable_flag;
        if (!cmd.enable_flag && !pinned) silence_motor();
      end
      default: ;
    endcase
    res.pin_level     = motor ^ active_low;
    res.busy_res      = playing | holding;
    res.step_position = playing ? pos : '0;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      loaded     = '0;
      allowed    = 1'b1;
      strength   = STR_NORMAL;
      active_low = 1'b0;
      silence_motor();
      pending_levels.delete();
      levels_due <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STRENGTH:   strength = cfg_data[STR_W-1:0];
          CFG_ACTIVE_LOW: active_low = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (pending_levels.size() == 0) begin
          $display("%0t: result transaction %h with nothing expected", $time, got);
          mismatches = mismatches + 1;
        end else begin
          want = pending_levels.pop_front();
          if (got.pin_level !== want.pin_level) begin
            $display("%0t: pin_level expected %0b actual %0b",
                     $time, want.pin_level, got.pin_level);
            mismatches = mismatches + 1;
          end
          if (got.busy_res !== want.busy_res) begin
            $display("%0t: busy_res expected %0b actual %0b",
                     $time, want.busy_res, got.busy_res);
            mismatches = mismatches + 1;
          end
          if (got.step_position !== want.step_position) begin
            $display("%0t: step_position expected %0d actual %0d",
                     $time, want.step_position, got.step_position);
            mismatches = mismatches + 1;
          end
        end
      end
      if (in_valid && !in_stall) pending_levels.push_back(advance_player(in_data));
      levels_due <= pending_levels.size();
    end
  end

endmodule

/* test/vibration_pattern_sequencer_test.sv */
// vibration_pattern_sequencer_test: drives command and register transactions into
// vibration_pattern_sequencer with random gaps and back-pressure, gives the verdict
// depends on vps_pkg, vibration_pattern_sequencer and pattern_player_checker
module vibration_pattern_sequencer_test;
  import vps_pkg::*;

  localparam logic [STR_W-1:0]  STR_STRONG   = 2'd2;
  localparam logic [STR_W-1:0]  STR_TOP      = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    levels_due;
  int                    mismatches;
  int                    items_sent = 0;
  bit                    burst = 1'b0;
  bit                    squeeze_req = 1'b0;

  vibration_pattern_sequencer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pattern_player_checker checker_inst (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .levels_due(levels_due), .mismatches(mismatches)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("vibration_pattern_sequencer test failed");
    $finish;
  end

  function automatic logic flip();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [DUR_W-1:0] rand_dur();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return DUR_W'($urandom_range(0, 4));
    if (r < 9) return DUR_W'($urandom_range(5, 30));
    return DUR_W'($urandom);
  endfunction

  task automatic send(input logic [MODE_W-1:0] mode, input logic [DUR_W-1:0] dur,
                      input logic scale, input logic force_bit, input logic en);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{mode: mode, duration: dur, scale_it: scale, force_req: force_bit,
                  enable_flag: en};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_tick();
    send(MODE_TICK, DUR_W'($urandom), flip(), flip(), flip());
  endtask

  task automatic send_noise();
    send(MODE_W'($urandom_range(0, 7)), DUR_W'($urandom), flip(), flip(),
         $urandom_range(0, 9) < 7);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (levels_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [STR_W-1:0] str, input logic inv);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_STRENGTH;
    cfg_data  <= str;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_ACTIVE_LOW;
    cfg_data  <= {1'b0, inv};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_traffic(input int quota);
    int stop_at;
    int r;
    int n;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if ($urandom_range(0, 2) == 0) begin
          send(MODE_ENABLE, DUR_W'($urandom), flip(), flip(), 1'b1);
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 6);
        repeat (n) send(MODE_LOAD, rand_dur(), flip(), flip(), flip());
        send(MODE_PLAY, DUR_W'($urandom), flip(), flip(), flip());
        n = $urandom_range(1, 40);
        repeat (n) begin
          if ($urandom_range(0, 19) == 0) send_noise();
          else send_tick();
        end
      end else if (r < 80) begin
        send(MODE_HOLD, rand_dur(), flip(), flip(), flip());
        n = $urandom_range(1, 20);
        repeat (n) begin
          if ($urandom_range(0, 14) == 0) send_noise();
          else send_tick();
        end
      end else begin
        repeat ($urandom_range(1, 5)) send_noise();
      end
    end
  endtask

  // receiver side: random stall pattern, plus one long hold-off on request
  initial begin
    int span;
    int r;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_stall <= 1'b1;
        span = 60;
      end else if (r < 45) begin
        out_stall <= 1'b0;
        span = $urandom_range(1, 6);
      end else if (r < 60) begin
        out_stall <= 1'b0;
        span = $urandom_range(20, 50);
      end else if (r < 90) begin
        out_stall <= 1'b1;
        span = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        span = $urandom_range(8, 25);
      end
      repeat (span) @(posedge clk);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    settle();
    write_regs(STR_STRONG, 1'b0);
    // saturating on step, halved gap, zero durations
    send(MODE_LOAD, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    send(MODE_LOAD, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    send(MODE_LOAD, 16'h0000, 1'b0, 1'b0, 1'b0);
    send(MODE_LOAD, 16'h0001, 1'b1, 1'b0, 1'b0);
    send(MODE_PLAY, 16'h0000, 1'b0, 1'b1, 1'b0);
    send(MODE_TICK, 16'h0000, 1'b0, 1'b0, 1'b0);
    // forced pattern survives plain stop and disable
    send(MODE_STOP, 16'h0000, 1'b0, 1'b0, 1'b0);
    send(MODE_ENABLE, 16'h0000, 1'b0, 1'b0, 1'b0);
    send(MODE_LOAD, 16'h0003, 1'b0, 1'b0, 1'b0);
    send(MODE_PLAY, 16'h0000, 1'b0, 1'b0, 1'b0);
    send(MODE_STOP, 16'h0000, 1'b0, 1'b1, 1'b0);
    send(MODE_ENABLE, 16'h0000, 1'b0, 1'b0, 1'b1);
    // zero hold lasts one tick, saturating forced hold
    send(MODE_HOLD, 16'h0000, 1'b1, 1'b0, 1'b0);
    send(MODE_TICK, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    send(MODE_HOLD, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    send(MODE_ENABLE, 16'h0000, 1'b0, 1'b0, 1'b0);
    send(MODE_STOP, 16'h0000, 1'b0, 1'b0, 1'b0);
    send(MODE_STOP, 16'h0000, 1'b0, 1'b1, 1'b0);
    send(MODE_ENABLE, 16'h0000, 1'b0, 1'b0, 1'b1);
    send(MODE_PLAY, 16'h0000, 1'b0, 1'b0, 1'b0);
    send(MODE_TICK, 16'h0000, 1'b0, 1'b0, 1'b0);
    send(MODE_TICK, 16'h0000, 1'b0, 1'b0, 1'b0);
    send(MODE_TICK, 16'h0000, 1'b0, 1'b0, 1'b0);
    send(MODE_SPARE_A, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    send(MODE_SPARE_B, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    send(MODE_PLAY, 16'h0000, 1'b0, 1'b1, 1'b1);
    random_traffic(120);

    settle();
    write_regs(STR_WEAK, 1'b1);
    squeeze_req = 1'b1;
    burst = 1'b1;
    random_traffic(80);
    burst = 1'b0;
    random_traffic(100);

    settle();
    write_regs(STR_NORMAL, 1'b0);
    random_traffic(150);

    settle();
    write_regs(STR_TOP, 1'b1);
    random_traffic(150);

    settle();
    write_regs(STR_STRONG, 1'b1);
    random_traffic(150);

    settle();
    write_regs(STR_WEAK, 1'b0);
    random_traffic(150);

    settle();
    write_regs(STR_NORMAL, 1'b1);
    burst = 1'b1;
    random_traffic(60);
    burst = 1'b0;
    random_traffic(80);

    settle();
    if (mismatches == 0) begin
      $display("vibration_pattern_sequencer test passed");
    end else begin
      $display("vibration_pattern_sequencer test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/vps_pkg.sv
hdl/vps_div100.sv
hdl/vibration_pattern_sequencer.sv
test/pattern_player_checker.sv
test/vibration_pattern_sequencer_test.sv
